>>> rtl/rlc_pkg.sv
// ----------------------------------------------------------------------------
// rlc_pkg
// Types and constants shared by the half-duplex RS485 link controller files.
// ----------------------------------------------------------------------------
package rlc_pkg;

  // command function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_PUSH  = 2'd1;
  localparam logic [1:0] FUNC_POP   = 2'd2;
  localparam logic [1:0] FUNC_RESET = 2'd3;

  // configuration space
  localparam int unsigned ADDR_W        = 3;
  localparam logic        REG_BACKOFF   = 1'b0;
  localparam logic [15:0] BACKOFF_RESET = 16'd100;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] host_byte;
    logic       uart_rx_valid;
    logic [7:0] uart_rx_byte;
    logic       uart_tx_full;
    logic       uart_tx_idle;
    logic [2:0] uart_error;
  } rlc_cmd_item_t;

  typedef struct packed {
    logic       uart_tx_valid;
    logic [7:0] uart_tx_byte;
    logic       uart_enable;
    logic       drive_enable;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       rx_nonempty;
    logic [1:0] link_status;
    logic [2:0] error_bits;
    logic       push_dropped;
    logic       uart_error_clear;
  } rlc_rsp_item_t;

  // classified command held in the queue between front and back
  typedef struct packed {
    logic       tick;
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] host_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tx_full;
    logic       tx_idle;
    logic [2:0] uart_error;
  } rlc_cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } rlc_fifo_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last;
  } rlc_fifo_stat_t;

endpackage

>>> rtl/rlc_if.sv
// ----------------------------------------------------------------------------
// rlc_if
// Valid/ready channels for commands into and results out of the controller.
// ----------------------------------------------------------------------------
interface rlc_cmd_if;
  import rlc_pkg::*;
  logic          valid;
  logic          ready;
  rlc_cmd_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rlc_rsp_if;
  import rlc_pkg::*;
  logic          valid;
  logic          ready;
  rlc_rsp_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/rlc_fifo.sv
// ----------------------------------------------------------------------------
// rlc_fifo
// Byte FIFO on a single memory with registered read and a show-ahead head.
// ----------------------------------------------------------------------------
module rlc_fifo import rlc_pkg::*; #(
  parameter int unsigned DEPTH = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  rlc_fifo_ctl_t  ctl,
  input  logic [7:0]     wdata,
  output rlc_fifo_stat_t stat,
  output logic [7:0]     head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [7:0]       mem [DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic [7:0]       rdata;
  logic             byp;
  logic [7:0]       byp_data;

  always_comb begin
    if (ctl.flush) begin
      rd_ptr_next = '0;
    end else if (ctl.pop) begin
      rd_ptr_next = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
    end else begin
      rd_ptr_next = rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
      byp    <= 1'b0;
    end else begin
      rd_ptr <= rd_ptr_next;
      byp    <= ctl.push && !ctl.flush && (wr_ptr == rd_ptr_next);
      if (ctl.flush) begin
        wr_ptr <= '0;
        count  <= '0;
      end else begin
        if (ctl.push) begin
          wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
        end
        if (ctl.push && !ctl.pop) begin
          count <= count + 1'b1;
        end else if (ctl.pop && !ctl.push) begin
          count <= count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata    <= mem[rd_ptr_next];
    byp_data <= wdata;
  end

  assign head       = byp ? byp_data : rdata;
  assign stat.full  = (count == CNT_FULL);
  assign stat.empty = (count == '0);
  assign stat.last  = (count == CNT_ONE);

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && !ctl.flush && stat.full))
    else $error("push into full fifo");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(ctl.pop && stat.empty))
    else $error("pop from empty fifo");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    stat.empty |-> (rd_ptr == wr_ptr))
    else $error("empty fifo with unequal pointers");
`endif

endmodule

>>> rtl/rlc_front.sv
// ----------------------------------------------------------------------------
// rlc_front
// Accepts commands, decodes the function code and queues them for the back.
// ----------------------------------------------------------------------------
module rlc_front import rlc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rlc_cmd_if.sink   cmd,
  output logic      q_valid,
  output rlc_cmd_t  q_item,
  input  logic      q_take
);

  rlc_cmd_t   slot [2];
  rlc_cmd_t   decoded;
  logic       wr_sel;
  logic       rd_sel;
  logic [1:0] fill;
  logic       accept;

  always_comb begin
    decoded            = '0;
    decoded.host_byte  = cmd.payload.host_byte;
    decoded.rx_valid   = cmd.payload.uart_rx_valid;
    decoded.rx_byte    = cmd.payload.uart_rx_byte;
    decoded.tx_full    = cmd.payload.uart_tx_full;
    decoded.tx_idle    = cmd.payload.uart_tx_idle;
    decoded.uart_error = cmd.payload.uart_error;
    unique case (cmd.payload.func)
      FUNC_TICK:  decoded.tick  = 1'b1;
      FUNC_PUSH:  decoded.push  = 1'b1;
      FUNC_POP:   decoded.pop   = 1'b1;
      FUNC_RESET: decoded.clear = 1'b1;
    endcase
  end

  assign cmd.ready = (fill != 2'd2);
  assign accept    = cmd.valid && cmd.ready;
  assign q_valid   = (fill != 2'd0);
  assign q_item    = slot[rd_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (accept) begin
        wr_sel <= ~wr_sel;
      end
      if (q_take) begin
        rd_sel <= ~rd_sel;
      end
      if (accept && !q_take) begin
        fill <= fill + 2'd1;
      end else if (q_take && !accept) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wr_sel] <= decoded;
    end
  end

endmodule

>>> rtl/rlc_back.sv
// ----------------------------------------------------------------------------
// rlc_back
// Link state machine, backoff counter, error latch and result register.
// ----------------------------------------------------------------------------
module rlc_back import rlc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    backoff_ticks,
  input  logic           q_valid,
  input  rlc_cmd_t       q_item,
  output logic           q_take,
  input  rlc_fifo_stat_t tx_stat,
  input  logic [7:0]     tx_head,
  output rlc_fifo_ctl_t  tx_ctl,
  output logic [7:0]     tx_wdata,
  input  rlc_fifo_stat_t rx_stat,
  input  logic [7:0]     rx_head,
  output rlc_fifo_ctl_t  rx_ctl,
  output logic [7:0]     rx_wdata,
  rlc_rsp_if.source      rsp
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_WAIT     = 3'd1;
  localparam logic [2:0] ST_RECEIVE  = 3'd2;
  localparam logic [2:0] ST_TRANSFER = 3'd3;
  localparam logic [2:0] ST_WRITE    = 3'd4;
  localparam logic [2:0] ST_DRAIN    = 3'd5;
  localparam logic [2:0] ST_ERROR    = 3'd6;
  localparam logic [2:0] ST_HALTED   = 3'd7;

  localparam logic [1:0] STAT_IDLE = 2'd0;
  localparam logic [1:0] STAT_RX   = 2'd1;
  localparam logic [1:0] STAT_TX   = 2'd2;
  localparam logic [1:0] STAT_ERR  = 2'd3;

  logic [2:0]    state, state_next;
  logic [1:0]    status, status_next;
  logic [2:0]    errors, errors_next;
  logic [15:0]   backoff, backoff_next;
  logic          drive, drive_next;
  logic          uart_on, uart_on_next;
  logic          restarted;
  logic          can_send;
  rlc_fifo_ctl_t tx_op, rx_op;
  rlc_rsp_item_t res;

  assign q_take   = q_valid && (!rsp.valid || rsp.ready);
  assign can_send = !tx_stat.empty && !q_item.tx_full;
  assign tx_wdata = q_item.host_byte;
  assign rx_wdata = q_item.rx_byte;

  always_comb begin
    state_next   = state;
    status_next  = status;
    errors_next  = errors;
    backoff_next = backoff;
    drive_next   = drive;
    uart_on_next = uart_on;
    restarted    = 1'b0;
    tx_op        = '0;
    rx_op        = '0;
    res          = '0;

    if (q_item.push) begin
      if (tx_stat.full) begin
        res.push_dropped = 1'b1;
      end else begin
        tx_op.push = 1'b1;
      end
    end else if (q_item.pop) begin
      if (!rx_stat.empty) begin
        res.read_valid = 1'b1;
        res.read_byte  = rx_head;
        rx_op.pop      = 1'b1;
      end
    end else if (q_item.clear) begin
      state_next   = ST_IDLE;
      status_next  = STAT_IDLE;
      errors_next  = '0;
      uart_on_next = 1'b1;
      drive_next   = 1'b0;
      tx_op.flush  = 1'b1;
      rx_op.flush  = 1'b1;
      res.uart_error_clear = 1'b1;
    end else begin
      unique case (state)
        ST_WAIT: begin
          if (q_item.rx_valid) begin
            status_next = STAT_RX;
            state_next  = ST_RECEIVE;
          end else if (can_send && backoff == '0) begin
            status_next = STAT_TX;
            state_next  = ST_TRANSFER;
          end else begin
            errors_next = errors | q_item.uart_error;
            state_next  = (errors_next != '0) ? ST_ERROR : ST_WAIT;
          end
        end
        ST_RECEIVE: begin
          if (q_item.rx_valid) begin
            if (rx_stat.full) begin
              res.push_dropped = 1'b1;
            end else begin
              rx_op.push = 1'b1;
            end
          end else begin
            backoff_next = backoff_ticks;
            restarted    = 1'b1;
            state_next   = ST_IDLE;
          end
        end
        ST_TRANSFER, ST_WRITE: begin
          if (state == ST_TRANSFER) begin
            drive_next = 1'b1;
          end
          if (can_send) begin
            res.uart_tx_valid = 1'b1;
            res.uart_tx_byte  = tx_head;
            tx_op.pop         = 1'b1;
            state_next        = ST_WRITE;
          end else begin
            state_next = ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (can_send) begin
            state_next = ST_WRITE;
          end else if (q_item.tx_idle) begin
            drive_next = 1'b0;
            state_next = ST_IDLE;
          end
        end
        ST_ERROR: begin
          uart_on_next = 1'b0;
          status_next  = STAT_ERR;
          state_next   = ST_HALTED;
        end
        ST_HALTED: begin
        end
        default: begin
          drive_next  = 1'b0;
          status_next = STAT_IDLE;
          state_next  = ST_WAIT;
        end
      endcase
      if (!restarted && backoff != '0) begin
        backoff_next = backoff - 16'd1;
      end
    end

    res.uart_enable  = uart_on_next;
    res.drive_enable = drive_next;
    res.link_status  = status_next;
    res.error_bits   = errors_next;
    if (rx_op.flush) begin
      res.rx_nonempty = 1'b0;
    end else if (rx_op.push) begin
      res.rx_nonempty = 1'b1;
    end else if (rx_op.pop) begin
      res.rx_nonempty = !rx_stat.last;
    end else begin
      res.rx_nonempty = !rx_stat.empty;
    end
  end

  assign tx_ctl.push  = tx_op.push && q_take;
  assign tx_ctl.pop   = tx_op.pop && q_take;
  assign tx_ctl.flush = tx_op.flush && q_take;
  assign rx_ctl.push  = rx_op.push && q_take;
  assign rx_ctl.pop   = rx_op.pop && q_take;
  assign rx_ctl.flush = rx_op.flush && q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      status    <= STAT_IDLE;
      errors    <= '0;
      backoff   <= BACKOFF_RESET;
      drive     <= 1'b0;
      uart_on   <= 1'b1;
      rsp.valid <= 1'b0;
    end else begin
      if (q_take) begin
        state     <= state_next;
        status    <= status_next;
        errors    <= errors_next;
        backoff   <= backoff_next;
        drive     <= drive_next;
        uart_on   <= uart_on_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      rsp.payload <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_drive_in_tx: assert property (@(posedge clk) disable iff (rst)
    drive |-> (state == ST_WRITE || state == ST_DRAIN))
    else $error("drive asserted outside transmit");

  a_off_halted: assert property (@(posedge clk) disable iff (rst)
    !uart_on |-> (state == ST_HALTED && status == STAT_ERR))
    else $error("uart disabled outside halted state");

  a_tx_driven: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.uart_tx_valid) |-> rsp.payload.drive_enable)
    else $error("byte sent without drive");

  a_tx_pop_send: assert property (@(posedge clk) disable iff (rst)
    tx_ctl.pop |=> (rsp.valid && rsp.payload.uart_tx_valid))
    else $error("transmit pop without result");
`endif

endmodule

>>> rtl/half_duplex_rs485_link_controller_unit.sv
// ----------------------------------------------------------------------------
// half_duplex_rs485_link_controller_unit
// RS485 half-duplex turnaround controller between a host and a UART.
// ----------------------------------------------------------------------------
// Commands arrive on the cmd channel (valid/ready); each one gives exactly one
// result on the rsp channel, in order. A command is tick, host push, host pop
// or reset-and-clear, with a snapshot of the UART status lines.
// A two-entry command queue sits between the decode front and the execute
// back, and the back writes each result into an output register, so a new
// command is taken every cycle while rsp is ready. A command goes from cmd
// into a queue slot, and its result from the back into the output register;
// throughput is one command per cycle while rsp is ready. When rsp stalls,
// the output register holds its result, the queue fills and cmd.ready
// drops after two more commands. Reset clears the queue and state machine,
// empties both FIFOs, enables the UART, releases the drive and loads the
// backoff count and backoff_ticks with 100. The user writes backoff_ticks
// over APB at address 0 only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module half_duplex_rs485_link_controller_unit import rlc_pkg::*; #(
  parameter int unsigned TX_DEPTH = 128,
  parameter int unsigned RX_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  rlc_cmd_if.sink           cmd,
  rlc_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [15:0]    backoff_ticks;
  logic           q_valid;
  rlc_cmd_t       q_item;
  logic           q_take;
  rlc_fifo_ctl_t  tx_ctl, rx_ctl;
  rlc_fifo_stat_t tx_stat, rx_stat;
  logic [7:0]     tx_wdata, rx_wdata;
  logic [7:0]     tx_head, rx_head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BACKOFF) ? {16'd0, backoff_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      backoff_ticks <= BACKOFF_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_BACKOFF) begin
      backoff_ticks <= pwdata[15:0];
    end
  end

  rlc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take)
  );

  rlc_fifo #(.DEPTH(TX_DEPTH)) u_tx_fifo (
    .clk   (clk),
    .rst   (rst),
    .ctl   (tx_ctl),
    .wdata (tx_wdata),
    .stat  (tx_stat),
    .head  (tx_head)
  );

  rlc_fifo #(.DEPTH(RX_DEPTH)) u_rx_fifo (
    .clk   (clk),
    .rst   (rst),
    .ctl   (rx_ctl),
    .wdata (rx_wdata),
    .stat  (rx_stat),
    .head  (rx_head)
  );

  rlc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .backoff_ticks (backoff_ticks),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_take        (q_take),
    .tx_stat       (tx_stat),
    .tx_head       (tx_head),
    .tx_ctl        (tx_ctl),
    .tx_wdata      (tx_wdata),
    .rx_stat       (rx_stat),
    .rx_head       (rx_head),
    .rx_ctl        (rx_ctl),
    .rx_wdata      (rx_wdata),
    .rsp           (rsp)
  );

endmodule
